@@ rtl/brss_pkg.sv @@
// Shared types and constants for the block range to slice splitter.
// No dependencies.
package brss_pkg;

	localparam logic [7:0] OP_WRITE    = 8'd1;
	localparam logic [7:0] OP_READ     = 8'd2;
	localparam int         MAX_RESULTS = 33;

	typedef struct packed {
		logic [7:0]  command_tag;
		logic [31:0] start_block;
		logic [11:0] count_minus_one;
		logic [7:0]  opcode;
	} brss_cmd_t;

	typedef struct packed {
		logic [7:0]  slice_tag;
		logic        is_write;
		logic [29:0] slice_address;
		logic [5:0]  block_offset;
		logic [6:0]  block_count;
		logic [11:0] transfer_index;
		logic        last;
		logic        error;
	} brss_slice_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_CHECK,
		ST_EMIT
	} brss_state_t;

endpackage

@@ rtl/block_range_to_slice_splitter.sv @@
// Block range to slice splitter: one host command in, slice transactions out; uses brss_pkg.
// Sequence: start_block / BLOCKS_PER_SLICE by reciprocal multiply on one shared 32x17
// multiplier (ST_MUL_LO, ST_MUL_HI), a check state (ST_CHECK), then in ST_EMIT one slice
// per unstalled output cycle into the output register. A command of N slices (N = 1 if
// rejected) holds cmd_stall high until its last slice is loaded; no command overlaps it.
// Reset clears the sequencer and the output valid; the datapath registers are not reset.
module block_range_to_slice_splitter #(
	parameter int BLOCKS_PER_SLICE = 4,
	parameter int MAX_BLOCKS       = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  brss_pkg::brss_cmd_t   cmd,
	output logic                  slc_valid,
	input  logic                  slc_stall,
	output brss_pkg::brss_slice_t slc
);

	// Slice number by reciprocal: q = (x * RECIP) >> (32 + SHIFT_L), exact for every
	// 32-bit x with RECIP = ceil(2^(32 + SHIFT_L) / BLOCKS_PER_SLICE), RECIP below 2^33.
	localparam int          SHIFT_L  = $clog2(BLOCKS_PER_SLICE);
	localparam int          Q_SHIFT  = 32 + SHIFT_L;
	localparam logic [63:0] RECIP_W  = ((64'd1 << Q_SHIFT) + 64'(BLOCKS_PER_SLICE) - 64'd1)
		/ 64'(BLOCKS_PER_SLICE);
	localparam logic [16:0] RECIP_LO = RECIP_W[16:0];
	localparam logic [15:0] RECIP_HI = RECIP_W[32:17];

	localparam logic [6:0]   BPS_CNT    = 7'(BLOCKS_PER_SLICE);
	localparam logic [12:0]  MAX_CNT    = 13'(MAX_BLOCKS);
	// More than MAX_RESULTS slices iff offset + count > MAX_RESULTS * size.
	localparam logic [13:0]  SPAN_LIMIT = 14'(brss_pkg::MAX_RESULTS * BLOCKS_PER_SLICE);

	brss_pkg::brss_state_t state_q, state_d;

	// Captured command.
	logic [7:0]    tag_q;
	logic [7:0]    op_q;
	logic [12:0]   cnt_q;        // block count, 1..4096
	logic [31:0]   start_q;

	// Product accumulator: low half of the reciprocal first, high half added next.
	logic [64:0]   prod_q;

	// Slice walk.
	logic [29:0]   slice_q;
	logic [5:0]    offset_q;
	logic [12:0]   remaining_q;
	logic [11:0]   issued_q;
	logic          err_q;

	logic          out_valid_q;
	brss_pkg::brss_slice_t out_q;

	// Combinational controls.
	logic          accept;
	logic          out_free;
	logic          load_out;
	logic [16:0]   mul_b;
	logic [48:0]   mul_out;
	logic [29:0]   quot;
	logic [6:0]    rem_full;
	logic [6:0]    room;
	logic [6:0]    take;
	logic [12:0]   remaining_next;
	logic          is_wr;
	logic          bad_cmd;
	logic [13:0]   span;

	assign cmd_stall = (state_q != brss_pkg::ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !out_valid_q || !slc_stall;

	// Shared multiplier: start block times one half of the reciprocal.
	assign mul_b   = (state_q == brss_pkg::ST_MUL_HI) ? {1'b0, RECIP_HI} : RECIP_LO;
	assign mul_out = 49'(start_q) * 49'(mul_b);

	// Slice number wraps at 30 bits; offset is recovered mod 128 (it is below 64).
	assign quot     = 30'(prod_q >> Q_SHIFT);
	assign rem_full = start_q[6:0] - quot[6:0] * BPS_CNT;

	assign room           = BPS_CNT - {1'b0, offset_q};
	assign take           = (remaining_q < {6'd0, room}) ? remaining_q[6:0] : room;
	assign remaining_next = remaining_q - {6'd0, take};

	assign is_wr   = (op_q == brss_pkg::OP_WRITE);
	assign span    = {7'd0, rem_full} + {1'b0, cnt_q};
	assign bad_cmd = ((op_q != brss_pkg::OP_WRITE) && (op_q != brss_pkg::OP_READ))
		|| (cnt_q > MAX_CNT) || (span > SPAN_LIMIT);

	// Sequencer: next state and output load.
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			brss_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = brss_pkg::ST_MUL_LO;
				end
			end
			brss_pkg::ST_MUL_LO: begin
				state_d = brss_pkg::ST_MUL_HI;
			end
			brss_pkg::ST_MUL_HI: begin
				state_d = brss_pkg::ST_CHECK;
			end
			brss_pkg::ST_CHECK: begin
				state_d = brss_pkg::ST_EMIT;
			end
			brss_pkg::ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (err_q || (remaining_next == 13'd0)) begin
						state_d = brss_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = brss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brss_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!slc_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			brss_pkg::ST_IDLE: begin
				if (accept) begin
					tag_q   <= cmd.command_tag;
					op_q    <= cmd.opcode;
					cnt_q   <= {1'b0, cmd.count_minus_one} + 13'd1;
					start_q <= cmd.start_block;
				end
			end
			brss_pkg::ST_MUL_LO: begin
				prod_q <= 65'(mul_out);
			end
			brss_pkg::ST_MUL_HI: begin
				prod_q <= prod_q + {mul_out[47:0], 17'd0};
			end
			brss_pkg::ST_CHECK: begin
				err_q       <= bad_cmd;
				slice_q     <= quot;
				offset_q    <= rem_full[5:0];
				remaining_q <= cnt_q;
				issued_q    <= '0;
			end
			brss_pkg::ST_EMIT: begin
				if (load_out) begin
					slice_q     <= slice_q + 30'd1;
					offset_q    <= '0;
					remaining_q <= remaining_next;
					issued_q    <= issued_q + 12'(take);
				end
			end
			default: begin
			end
		endcase

		if (load_out) begin
			out_q.slice_tag <= tag_q;
			out_q.is_write  <= is_wr;
			if (err_q) begin
				out_q.slice_address  <= '0;
				out_q.block_offset   <= '0;
				out_q.block_count    <= '0;
				out_q.transfer_index <= '0;
				out_q.last           <= 1'b1;
				out_q.error          <= 1'b1;
			end else begin
				out_q.slice_address  <= slice_q;
				out_q.block_offset   <= offset_q;
				out_q.block_count    <= take;
				out_q.transfer_index <= issued_q;
				out_q.last           <= (remaining_next == 13'd0);
				out_q.error          <= 1'b0;
			end
		end
	end

	assign slc_valid = out_valid_q;
	assign slc       = out_q;

endmodule
